// ===== rtl/vbsu_pkg.sv =====
package vbsu_pkg;

  // Default table depths
  localparam int unsigned PC_SLOTS_DEF = 8;
  localparam int unsigned OP_SLOTS_DEF = 8;

  // Field widths
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned TASK_W  = 7;
  localparam int unsigned PC_W    = 32;
  localparam int unsigned OP_W    = 8;
  localparam int unsigned CAUSE_W = 2;
  localparam int unsigned TSEL_W  = 8;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_USED_W = 1 + CAUSE_W + 1 + 1 + TASK_W + PC_W + OP_W;

  // Configuration port
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  localparam logic [1:0] REG_ENABLE    = 2'd0;
  localparam logic [1:0] REG_STEP_MODE = 2'd1;
  localparam logic [1:0] REG_TASK_SEL  = 2'd2;

  // Reset value of the task filter: negative, so every task is watched
  localparam logic [TSEL_W-1:0] TASK_SEL_RESET = 8'hFF;

  typedef enum logic [REQ_W-1:0] {
    REQ_DISPATCH  = 3'd0,
    REQ_STEP      = 3'd1,
    REQ_ADD_PC    = 3'd2,
    REQ_REMOVE_PC = 3'd3,
    REQ_CLEAR_PC  = 3'd4,
    REQ_ADD_OP    = 3'd5,
    REQ_REMOVE_OP = 3'd6,
    REQ_CLEAR_OP  = 3'd7
  } req_e;

  typedef enum logic [CAUSE_W-1:0] {
    CAUSE_NONE = 2'd0,
    CAUSE_STEP = 2'd1,
    CAUSE_PC   = 2'd2,
    CAUSE_OP   = 2'd3
  } cause_e;

  typedef enum logic [1:0] {
    TBL_SEARCH = 2'd0,
    TBL_ADD    = 2'd1,
    TBL_REMOVE = 2'd2,
    TBL_CLEAR  = 2'd3
  } tbl_op_e;

  typedef struct packed {
    logic    start;
    tbl_op_e op;
  } tbl_cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic ok;
  } tbl_sts_t;

endpackage

// ===== rtl/vm_breakpoint_step_unit_top.sv =====
// Breakpoint and single-step unit for a bytecode machine.
// Requests arrive on the s_axis channel, one transfer per item: tuser holds
// the request kind (dispatch, step, add/remove/clear of a pc or opcode
// breakpoint), tdata the task, program counter and opcode. Each request
// produces exactly one result transfer on m_axis carrying hold, the new pause
// cause, the ok flag, the paused flag and the recorded snapshot.
// The unit handles one request at a time. Both breakpoint tables are rows of
// cells that a search token crosses one cell per cycle, so the longer row
// sets how long a request takes. A request is accepted, both tables work on
// it, the result is registered once both are done and then moves to the
// output register, and only then is the next request accepted.
// Configuration (enable, step mode, task filter) is written through the APB
// port; the user must write it only while no request is in flight, which the
// block itself does not enforce. Disabling the unit drops any pause.
// After reset the unit is disabled, nothing is paused, both tables are empty
// and the filter watches all tasks. Table entries are not cleared; entries
// past the fill count are never looked at. When m_axis stalls, the result
// stays in its output register; the next request is still accepted and
// worked on, and waits only for that register before its own result moves.
module vm_breakpoint_step_unit_top #(
  parameter int unsigned PC_SLOTS = vbsu_pkg::PC_SLOTS_DEF,
  parameter int unsigned OP_SLOTS = vbsu_pkg::OP_SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Request channel
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: task_num [6:0], prog_addr [38:7], op_byte [46:39], zero [47]
  input  logic [vbsu_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: req_type [2:0]
  input  logic [vbsu_pkg::REQ_W-1:0]      s_axis_tuser,
  // Result channel
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: hold [0], cause [2:1], ok [3], is_paused [4], snap_task [11:5],
  //        snap_pc [43:12], snap_op [51:44], zero [55:52]
  output logic [vbsu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [vbsu_pkg::CFG_AW-1:0]     paddr,
  input  logic [vbsu_pkg::CFG_DW-1:0]     pwdata,
  output logic [vbsu_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready
);

  localparam int unsigned TW = vbsu_pkg::TASK_W;
  localparam int unsigned PW = vbsu_pkg::PC_W;
  localparam int unsigned OW = vbsu_pkg::OP_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } top_state_e;

  top_state_e state_q;

  // Request being worked on
  vbsu_pkg::req_e req_q;
  logic [TW-1:0]  task_q;
  logic [PW-1:0]  pc_q;
  logic [OW-1:0]  opb_q;

  // Table results collected while the search tokens travel
  logic pc_done_q, op_done_q;
  logic pc_hit_q, op_hit_q;
  logic pc_ok_q, op_ok_q;

  // Configuration registers
  logic                            en_q;
  logic                            ssm_q;
  logic [vbsu_pkg::TSEL_W-1:0]     tsel_q;

  // Debug state
  logic          paused_q, stepp_q;
  logic [TW-1:0] ptask_q;
  logic [PW-1:0] ppc_q;
  logic [OW-1:0] pop_q;

  logic [vbsu_pkg::OUT_USED_W-1:0] res_q;
  logic                            m_valid_q;
  logic [vbsu_pkg::OUT_DATA_W-1:0] m_data_q;

  // Table interfaces
  vbsu_pkg::tbl_cmd_t pc_cmd, op_cmd;
  vbsu_pkg::tbl_sts_t pc_sts, op_sts;
  vbsu_pkg::req_e     in_req;
  logic               accept;
  logic               cfg_wr;

  // Request evaluation
  logic            pc_hit, op_hit, pc_ok, op_ok, all_done;
  logic            filter, blocked;
  logic            paused_d, stepp_d;
  logic [TW-1:0]   ptask_d;
  logic [PW-1:0]   ppc_d;
  logic [OW-1:0]   pop_d;
  logic            hold;
  vbsu_pkg::cause_e cause;
  logic            ok;

  assign in_req        = vbsu_pkg::req_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_wr        = psel && penable && pwrite && pready;
  assign pready        = 1'b1;

  // Both tables start on every request; the one not addressed just searches,
  // which a dispatch needs anyway.
  always_comb begin
    pc_cmd.start = accept;
    op_cmd.start = accept;
    pc_cmd.op    = vbsu_pkg::TBL_SEARCH;
    op_cmd.op    = vbsu_pkg::TBL_SEARCH;
    case (in_req)
      vbsu_pkg::REQ_ADD_PC:    pc_cmd.op = vbsu_pkg::TBL_ADD;
      vbsu_pkg::REQ_REMOVE_PC: pc_cmd.op = vbsu_pkg::TBL_REMOVE;
      vbsu_pkg::REQ_CLEAR_PC:  pc_cmd.op = vbsu_pkg::TBL_CLEAR;
      vbsu_pkg::REQ_ADD_OP:    op_cmd.op = vbsu_pkg::TBL_ADD;
      vbsu_pkg::REQ_REMOVE_OP: op_cmd.op = vbsu_pkg::TBL_REMOVE;
      vbsu_pkg::REQ_CLEAR_OP:  op_cmd.op = vbsu_pkg::TBL_CLEAR;
      default: begin
      end
    endcase
  end

  vbsu_chain #(
    .W    (PW),
    .SLOTS(PC_SLOTS)
  ) u_pc_tbl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (pc_cmd),
    .value_i(s_axis_tdata[TW +: PW]),
    .sts_o  (pc_sts)
  );

  vbsu_chain #(
    .W    (OW),
    .SLOTS(OP_SLOTS)
  ) u_op_tbl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (op_cmd),
    .value_i(s_axis_tdata[TW+PW +: OW]),
    .sts_o  (op_sts)
  );

  // A table's status may arrive in the very cycle the request completes.
  assign pc_hit   = pc_sts.done ? pc_sts.hit : pc_hit_q;
  assign op_hit   = op_sts.done ? op_sts.hit : op_hit_q;
  assign pc_ok    = pc_sts.done ? pc_sts.ok : pc_ok_q;
  assign op_ok    = op_sts.done ? op_sts.ok : op_ok_q;
  assign all_done = (pc_done_q || pc_sts.done) && (op_done_q || op_sts.done);

  // A negative filter value watches every task.
  assign filter = en_q && (tsel_q[vbsu_pkg::TSEL_W-1] || (tsel_q[TW-1:0] == task_q));

  always_comb begin
    paused_d = paused_q;
    stepp_d  = stepp_q;
    ptask_d  = ptask_q;
    ppc_d    = ppc_q;
    pop_d    = pop_q;
    hold     = 1'b0;
    cause    = vbsu_pkg::CAUSE_NONE;
    ok       = 1'b0;
    blocked  = 1'b0;
    case (req_q)
      vbsu_pkg::REQ_DISPATCH: begin
        if (filter) begin
          // The paused task itself passes once if a step was granted.
          if (paused_q && (ptask_q == task_q)) begin
            if (stepp_q) begin
              stepp_d  = 1'b0;
              paused_d = 1'b0;
            end else begin
              blocked = 1'b1;
              hold    = 1'b1;
            end
          end
          if (!blocked) begin
            if (ssm_q) begin
              cause = vbsu_pkg::CAUSE_STEP;
            end else if (pc_hit) begin
              cause = vbsu_pkg::CAUSE_PC;
            end else if (op_hit) begin
              cause = vbsu_pkg::CAUSE_OP;
            end
            if (cause != vbsu_pkg::CAUSE_NONE) begin
              paused_d = 1'b1;
              ptask_d  = task_q;
              ppc_d    = pc_q;
              pop_d    = opb_q;
              hold     = 1'b1;
            end
          end
        end
      end
      vbsu_pkg::REQ_STEP: begin
        if (paused_q) begin
          stepp_d = 1'b1;
          ok      = 1'b1;
        end
      end
      vbsu_pkg::REQ_ADD_PC, vbsu_pkg::REQ_REMOVE_PC, vbsu_pkg::REQ_CLEAR_PC: begin
        ok = pc_ok;
      end
      vbsu_pkg::REQ_ADD_OP, vbsu_pkg::REQ_REMOVE_OP, vbsu_pkg::REQ_CLEAR_OP: begin
        ok = op_ok;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      req_q     <= vbsu_pkg::REQ_DISPATCH;
      task_q    <= '0;
      pc_q      <= '0;
      opb_q     <= '0;
      pc_done_q <= 1'b0;
      op_done_q <= 1'b0;
      pc_hit_q  <= 1'b0;
      op_hit_q  <= 1'b0;
      pc_ok_q   <= 1'b0;
      op_ok_q   <= 1'b0;
      en_q      <= 1'b0;
      ssm_q     <= 1'b0;
      tsel_q    <= vbsu_pkg::TASK_SEL_RESET;
      paused_q  <= 1'b0;
      stepp_q   <= 1'b0;
      ptask_q   <= '0;
      ppc_q     <= '0;
      pop_q     <= '0;
      res_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q     <= in_req;
            task_q    <= s_axis_tdata[0 +: TW];
            pc_q      <= s_axis_tdata[TW +: PW];
            opb_q     <= s_axis_tdata[TW+PW +: OW];
            pc_done_q <= 1'b0;
            op_done_q <= 1'b0;
            state_q   <= S_RUN;
          end
        end
        S_RUN: begin
          if (pc_sts.done) begin
            pc_done_q <= 1'b1;
            pc_hit_q  <= pc_sts.hit;
            pc_ok_q   <= pc_sts.ok;
          end
          if (op_sts.done) begin
            op_done_q <= 1'b1;
            op_hit_q  <= op_sts.hit;
            op_ok_q   <= op_sts.ok;
          end
          if (all_done) begin
            paused_q <= paused_d;
            stepp_q  <= stepp_d;
            ptask_q  <= ptask_d;
            ppc_q    <= ppc_d;
            pop_q    <= pop_d;
            res_q    <= {pop_d, ppc_d, ptask_d, paused_d, ok, cause, hold};
            state_q  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {{(vbsu_pkg::OUT_DATA_W - vbsu_pkg::OUT_USED_W){1'b0}}, res_q};
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      // The user writes only while no request is in flight; unchecked here.
      if (cfg_wr) begin
        case (paddr[3:2])
          vbsu_pkg::REG_ENABLE: begin
            en_q <= pwdata[0];
            if (!pwdata[0]) begin
              paused_q <= 1'b0;
              stepp_q  <= 1'b0;
            end
          end
          vbsu_pkg::REG_STEP_MODE: ssm_q  <= pwdata[0];
          vbsu_pkg::REG_TASK_SEL:  tsel_q <= pwdata[vbsu_pkg::TSEL_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[3:2])
      vbsu_pkg::REG_ENABLE:    prdata = {{(vbsu_pkg::CFG_DW-1){1'b0}}, en_q};
      vbsu_pkg::REG_STEP_MODE: prdata = {{(vbsu_pkg::CFG_DW-1){1'b0}}, ssm_q};
      vbsu_pkg::REG_TASK_SEL:
        prdata = {{(vbsu_pkg::CFG_DW-vbsu_pkg::TSEL_W){1'b0}}, tsel_q};
      default:                 prdata = '0;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== rtl/vbsu_cell.sv =====
// One table entry plus one stage of the search token that walks the row.
module vbsu_cell #(
  parameter int unsigned W     = 32,
  parameter int unsigned SLOTS = 8,
  parameter int unsigned K     = 0
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        tok_valid_i,
  input  logic                                        tok_found_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] tok_at_i,
  input  logic [W-1:0]                                tok_last_i,
  output logic                                        tok_valid_o,
  output logic                                        tok_found_o,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] tok_at_o,
  output logic [W-1:0]                                tok_last_o,
  input  logic [W-1:0]                                query_i,
  input  logic [$clog2(SLOTS+1)-1:0]                  count_i,
  input  logic                                        we_i,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] widx_i,
  input  logic [W-1:0]                                wdata_i
);

  localparam int unsigned IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW   = $clog2(SLOTS+1);

  logic [W-1:0]    entry_q;
  logic            valid_q;
  logic            found_q;
  logic [IDXW-1:0] at_q;
  logic [W-1:0]    last_q;
  logic            in_use;
  logic            at_end;
  logic            match;

  assign in_use = count_i > CW'(K);
  assign at_end = count_i == CW'(K + 1);
  assign match  = tok_valid_i && in_use && !tok_found_i && (entry_q == query_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= tok_found_i | match;
    at_q    <= match ? IDXW'(K) : tok_at_i;
    last_q  <= at_end ? entry_q : tok_last_i;
    if (we_i && (widx_i == IDXW'(K))) begin
      entry_q <= wdata_i;
    end
  end

  assign tok_valid_o = valid_q;
  assign tok_found_o = found_q;
  assign tok_at_o    = at_q;
  assign tok_last_o  = last_q;

endmodule

// ===== rtl/vbsu_chain.sv =====
// Breakpoint table built as a row of cells. A search token enters the first
// cell and moves one cell per cycle; on leaving the row it carries the first
// match index and the last valid entry, which the table controller uses to
// finish an add or a remove.
module vbsu_chain #(
  parameter int unsigned W     = 32,
  parameter int unsigned SLOTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vbsu_pkg::tbl_cmd_t cmd_i,
  input  logic [W-1:0]       value_i,
  output vbsu_pkg::tbl_sts_t sts_o
);

  localparam int unsigned IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW   = $clog2(SLOTS+1);

  typedef enum logic {
    C_IDLE,
    C_SEARCH
  } chain_state_e;

  chain_state_e       state_q;
  vbsu_pkg::tbl_op_e  op_q;
  logic [W-1:0]       query_q;
  logic [CW-1:0]      count_q;
  logic               launch_q;
  logic               we_q;
  logic [IDXW-1:0]    widx_q;
  logic [W-1:0]       wdata_q;
  vbsu_pkg::tbl_sts_t sts_q;

  logic            tv     [0:SLOTS];
  logic            tfound [0:SLOTS];
  logic [IDXW-1:0] tat    [0:SLOTS];
  logic [W-1:0]    tlast  [0:SLOTS];

  assign tv[0]     = launch_q;
  assign tfound[0] = 1'b0;
  assign tat[0]    = '0;
  assign tlast[0]  = '0;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    vbsu_cell #(
      .W    (W),
      .SLOTS(SLOTS),
      .K    (k)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_valid_i(tv[k]),
      .tok_found_i(tfound[k]),
      .tok_at_i   (tat[k]),
      .tok_last_i (tlast[k]),
      .tok_valid_o(tv[k+1]),
      .tok_found_o(tfound[k+1]),
      .tok_at_o   (tat[k+1]),
      .tok_last_o (tlast[k+1]),
      .query_i    (query_q),
      .count_i    (count_q),
      .we_i       (we_q),
      .widx_i     (widx_q),
      .wdata_i    (wdata_q)
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= C_IDLE;
      op_q     <= vbsu_pkg::TBL_SEARCH;
      query_q  <= '0;
      count_q  <= '0;
      launch_q <= 1'b0;
      we_q     <= 1'b0;
      widx_q   <= '0;
      wdata_q  <= '0;
      sts_q    <= '0;
    end else begin
      launch_q   <= 1'b0;
      we_q       <= 1'b0;
      sts_q.done <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (cmd_i.start) begin
            op_q    <= cmd_i.op;
            query_q <= value_i;
            if (cmd_i.op == vbsu_pkg::TBL_CLEAR) begin
              count_q <= '0;
              sts_q   <= '{done: 1'b1, hit: 1'b0, ok: 1'b1};
            end else begin
              launch_q <= 1'b1;
              state_q  <= C_SEARCH;
            end
          end
        end
        C_SEARCH: begin
          if (tv[SLOTS]) begin
            state_q   <= C_IDLE;
            sts_q.done <= 1'b1;
            sts_q.hit  <= tfound[SLOTS];
            sts_q.ok   <= 1'b0;
            case (op_q)
              vbsu_pkg::TBL_ADD: begin
                // A full table refuses even a value it already holds.
                if (count_q != CW'(SLOTS)) begin
                  sts_q.ok <= 1'b1;
                  if (!tfound[SLOTS]) begin
                    we_q    <= 1'b1;
                    widx_q  <= count_q[IDXW-1:0];
                    wdata_q <= query_q;
                    count_q <= count_q + CW'(1);
                  end
                end
              end
              vbsu_pkg::TBL_REMOVE: begin
                if (tfound[SLOTS]) begin
                  sts_q.ok <= 1'b1;
                  we_q     <= 1'b1;
                  widx_q   <= tat[SLOTS];
                  wdata_q  <= tlast[SLOTS];
                  count_q  <= count_q - CW'(1);
                end
              end
              default: begin
              end
            endcase
          end
        end
        default: begin
          state_q <= C_IDLE;
        end
      endcase
    end
  end

  assign sts_o = sts_q;

endmodule

// ===== rtl/vbsu_checker.sv =====
module vbsu_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [vbsu_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                            pready
);

  logic                               hold;
  logic [vbsu_pkg::CAUSE_W-1:0]       cause;
  logic                               ok;
  logic                               is_paused;

  assign hold      = m_axis_tdata[0];
  assign cause     = m_axis_tdata[2:1];
  assign ok        = m_axis_tdata[3];
  assign is_paused = m_axis_tdata[4];

  // A stalled result keeps its value until it is taken.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The configuration port never inserts wait states.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  // A new pause always holds the dispatch and leaves the task paused.
  a_cause_pauses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (cause != vbsu_pkg::CAUSE_NONE) |-> hold && is_paused)
    else $error("pause cause without hold or paused flag");

  // Success is reported only for commands, which never hold or pause.
  a_ok_not_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ok |-> !hold && (cause == vbsu_pkg::CAUSE_NONE))
    else $error("ok set on a dispatch result");

endmodule

bind vm_breakpoint_step_unit_top vbsu_checker u_vbsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .pready       (pready)
);

// ===== dv/vm_breakpoint_step_unit_top_tb.sv =====
module vm_breakpoint_step_unit_top_tb;
  import vbsu_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int SETTLE_CYCLES = 2 * (PC_SLOTS_DEF + 4);
  localparam int LIMIT_CYCLES  = 400000;
  localparam int LONG_HOLD     = 150;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 112;
  localparam int PC_TBL        = 0;
  localparam int OP_TBL        = 1;
  localparam int TBL_DEPTH     = (PC_SLOTS_DEF > OP_SLOTS_DEF) ? PC_SLOTS_DEF : OP_SLOTS_DEF;

  typedef struct packed {
    logic        hold;
    cause_e      cause;
    logic        ok;
    logic        paused;
    logic [6:0]  snap_task;
    logic [31:0] snap_pc;
    logic [7:0]  snap_op;
  } debug_result_t;

  typedef struct packed {
    logic          valid;
    debug_result_t res;
  } pinned_entry_t;

  typedef struct {
    logic          is_cfg;
    logic [1:0]    cfg_reg;
    logic [7:0]    cfg_val;
    req_e          req;
    logic [6:0]    tsk;
    logic [31:0]   pc;
    logic [7:0]    op;
    logic          pinned;
    debug_result_t pin;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [REQ_W-1:0]      s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_AW-1:0]     paddr = '0;
  logic [CFG_DW-1:0]     pwdata = '0;
  logic [CFG_DW-1:0]     prdata;
  logic                  pready;

  vm_breakpoint_step_unit_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow of the unit: registers, pause state, snapshot and both tables.
  logic        unit_on      = 1'b0;
  logic        single_on    = 1'b0;
  logic [7:0]  watch_sel    = TASK_SEL_RESET;
  logic        held         = 1'b0;
  logic        step_granted = 1'b0;
  logic [6:0]  snap_task_q  = '0;
  logic [31:0] snap_pc_q    = '0;
  logic [7:0]  snap_op_q    = '0;
  logic [31:0] bp_tab [2][TBL_DEPTH];
  int          bp_cnt [2] = '{0, 0};

  debug_result_t pending_results [$];
  pinned_entry_t pinned_results [$];

  int  items_sent      = 0;
  int  dispatches_sent = 0;
  int  results_seen    = 0;
  int  pauses_seen     = 0;
  int  holds_seen      = 0;
  int  reg_writes      = 0;
  int  fail_count      = 0;
  int  phase_idx       = -1;
  bit  calm            = 1'b0;
  bit  long_hold_done  = 1'b0;

  function automatic int find_bp(int t, logic [31:0] v);
    for (int i = 0; i < bp_cnt[t]; i++)
      if (bp_tab[t][i] == v) return i;
    return -1;
  endfunction

  // A full table refuses every add, a value already present counts as added.
  function automatic logic add_bp(int t, logic [31:0] v);
    if (bp_cnt[t] >= ((t == PC_TBL) ? PC_SLOTS_DEF : OP_SLOTS_DEF)) return 1'b0;
    if (find_bp(t, v) < 0) begin
      bp_tab[t][bp_cnt[t]] = v;
      bp_cnt[t]++;
    end
    return 1'b1;
  endfunction

  // The last entry moves into the freed slot.
  function automatic logic remove_bp(int t, logic [31:0] v);
    int at;
    at = find_bp(t, v);
    if (at < 0) return 1'b0;
    bp_cnt[t]--;
    bp_tab[t][at] = bp_tab[t][bp_cnt[t]];
    return 1'b1;
  endfunction

  function automatic debug_result_t predict_debug_result(req_e req, logic [6:0] tsk,
                                                         logic [31:0] pc, logic [7:0] op);
    debug_result_t r;
    logic          blocked;
    r = '0;
    blocked = 1'b0;
    case (req)
      REQ_DISPATCH: begin
        if (unit_on && (watch_sel[7] || watch_sel[6:0] == tsk)) begin
          if (held && snap_task_q == tsk) begin
            if (step_granted) begin
              step_granted = 1'b0;
              held = 1'b0;
            end else begin
              blocked = 1'b1;
              r.hold = 1'b1;
            end
          end
          if (!blocked) begin
            if (single_on) r.cause = CAUSE_STEP;
            else if (find_bp(PC_TBL, pc) >= 0) r.cause = CAUSE_PC;
            else if (find_bp(OP_TBL, {24'h0, op}) >= 0) r.cause = CAUSE_OP;
            if (r.cause != CAUSE_NONE) begin
              held = 1'b1;
              snap_task_q = tsk;
              snap_pc_q = pc;
              snap_op_q = op;
              r.hold = 1'b1;
            end
          end
        end
      end
      REQ_STEP: begin
        if (held) begin
          step_granted = 1'b1;
          r.ok = 1'b1;
        end
      end
      REQ_ADD_PC:    r.ok = add_bp(PC_TBL, pc);
      REQ_REMOVE_PC: r.ok = remove_bp(PC_TBL, pc);
      REQ_CLEAR_PC: begin
        bp_cnt[PC_TBL] = 0;
        r.ok = 1'b1;
      end
      REQ_ADD_OP:    r.ok = add_bp(OP_TBL, {24'h0, op});
      REQ_REMOVE_OP: r.ok = remove_bp(OP_TBL, {24'h0, op});
      default: begin
        bp_cnt[OP_TBL] = 0;
        r.ok = 1'b1;
      end
    endcase
    r.paused = held;
    r.snap_task = snap_task_q;
    r.snap_pc = snap_pc_q;
    r.snap_op = snap_op_q;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Result checking, request prediction and register shadowing, all sampled
  // on the rising edge so that only settled values are seen.
  always @(posedge clk) begin : scoreboard
    debug_result_t got;
    debug_result_t want;
    debug_result_t predicted;
    pinned_entry_t pin;
    if (rst_n) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.hold = m_axis_tdata[0];
        got.cause = cause_e'(m_axis_tdata[2:1]);
        got.ok = m_axis_tdata[3];
        got.paused = m_axis_tdata[4];
        got.snap_task = m_axis_tdata[11:5];
        got.snap_pc = m_axis_tdata[43:12];
        got.snap_op = m_axis_tdata[51:44];
        results_seen++;
        if (got.cause != CAUSE_NONE) pauses_seen++;
        if (got.hold) holds_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, expected none, got %h",
                   $time, m_axis_tdata);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("hold", 32'(want.hold), 32'(got.hold));
          check_field("cause", 32'(want.cause), 32'(got.cause));
          check_field("ok", 32'(want.ok), 32'(got.ok));
          check_field("is_paused", 32'(want.paused), 32'(got.paused));
          check_field("snap_task", 32'(want.snap_task), 32'(got.snap_task));
          check_field("snap_pc", want.snap_pc, got.snap_pc);
          check_field("snap_op", 32'(want.snap_op), 32'(got.snap_op));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = predict_debug_result(req_e'(s_axis_tuser), s_axis_tdata[6:0],
                                         s_axis_tdata[38:7], s_axis_tdata[46:39]);
        pin = (pinned_results.size() != 0) ? pinned_results.pop_front() : '0;
        pending_results.push_back(pin.valid ? pin.res : predicted);
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ENABLE: begin
            unit_on = pwdata[0];
            if (!unit_on) begin
              held = 1'b0;
              step_granted = 1'b0;
            end
          end
          REG_STEP_MODE: single_on = pwdata[0];
          REG_TASK_SEL:  watch_sel = pwdata[7:0];
          default: ;
        endcase
      end
    end
  end

  task automatic write_register(logic [1:0] idx, logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // Drops tvalid and waits until every request has returned its result.
  task automatic wait_until_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_seen != items_sent) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_request(req_e req, logic [6:0] tsk, logic [31:0] pc, logic [7:0] op,
                              logic pinned, debug_result_t pin);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    pinned_results.push_back('{pinned, pin});
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {1'b0, op, pc, tsk};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    items_sent++;
    if (req == REQ_DISPATCH) dispatches_sent++;
  endtask

  function automatic stim_row_t req_row(req_e req, logic [6:0] tsk, logic [31:0] pc,
                                        logic [7:0] op);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.cfg_reg = REG_ENABLE;
    r.cfg_val = '0;
    r.req = req;
    r.tsk = tsk;
    r.pc = pc;
    r.op = op;
    r.pinned = 1'b0;
    r.pin = '0;
    return r;
  endfunction

  // Only used while the unit is off and nothing is paused, so every field
  // but ok is known to be zero.
  function automatic stim_row_t pinned_row(req_e req, logic [6:0] tsk, logic [31:0] pc,
                                           logic [7:0] op, logic ok);
    stim_row_t r;
    r = req_row(req, tsk, pc, op);
    r.pinned = 1'b1;
    r.pin.ok = ok;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [1:0] reg_sel, logic [7:0] val);
    stim_row_t r;
    r = req_row(REQ_DISPATCH, '0, '0, '0);
    r.is_cfg = 1'b1;
    r.cfg_reg = reg_sel;
    r.cfg_val = val;
    return r;
  endfunction

  // Result side: random ready bursts, one long hold-off in the third random
  // phase so the unit backs up into the request channel, and steady ready at
  // the end.
  initial begin : result_sink
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (calm) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else if (phase_idx == 2 && !long_hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("vm_breakpoint_step_unit_top verification failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   rows [$];
    logic [31:0] fill_pcs [8];
    logic [31:0] pc_pool [10];
    logic [7:0]  op_pool [10];
    logic [7:0]  phase_sel [PHASES];
    logic        phase_on [PHASES];
    logic        phase_step [PHASES];
    req_e        req;
    logic [6:0]  tsk;
    logic [31:0] pc;
    logic [7:0]  op;
    int          pick;

    fill_pcs = '{32'hFFFF_FFFF, 32'h0, 32'h1, 32'h2, 32'h3, 32'h4, 32'h5, 32'h8000_0000};
    phase_on = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1};
    phase_step = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    phase_sel = '{8'hFF, 8'hFF, 8'd127, 8'd0, 8'h80, 8'd0, 8'd0, 8'hFF};
    foreach (pc_pool[k]) pc_pool[k] = $urandom;
    foreach (op_pool[k]) op_pool[k] = 8'($urandom_range(0, 255));
    pc_pool[0] = 32'h0;
    pc_pool[1] = 32'hFFFF_FFFF;
    op_pool[0] = 8'h00;
    op_pool[1] = 8'hFF;

    // Unit off after reset: dispatches pass untouched, tables still work.
    rows.push_back(pinned_row(REQ_DISPATCH, 7'd0, 32'h0, 8'h00, 1'b0));
    rows.push_back(pinned_row(REQ_DISPATCH, 7'd127, 32'hFFFF_FFFF, 8'hFF, 1'b0));
    rows.push_back(pinned_row(REQ_STEP, 7'd0, 32'h0, 8'h00, 1'b0));
    rows.push_back(pinned_row(REQ_REMOVE_PC, 7'd0, 32'hFFFF_FFFF, 8'h00, 1'b0));
    rows.push_back(pinned_row(REQ_REMOVE_OP, 7'd0, 32'h0, 8'hFF, 1'b0));
    rows.push_back(pinned_row(REQ_CLEAR_PC, 7'd0, 32'h0, 8'h00, 1'b1));
    rows.push_back(pinned_row(REQ_CLEAR_OP, 7'd0, 32'h0, 8'h00, 1'b1));
    rows.push_back(pinned_row(REQ_ADD_OP, 7'd0, 32'h0, 8'h00, 1'b1));
    foreach (fill_pcs[k]) rows.push_back(pinned_row(REQ_ADD_PC, 7'd0, fill_pcs[k], 8'h00, 1'b1));
    // The pc table is full now: even a value already present is refused.
    rows.push_back(pinned_row(REQ_ADD_PC, 7'd0, 32'hFFFF_FFFF, 8'h00, 1'b0));
    rows.push_back(pinned_row(REQ_ADD_PC, 7'd0, 32'h1234_5678, 8'h00, 1'b0));
    rows.push_back(req_row(REQ_REMOVE_PC, 7'd0, 32'h0, 8'h00));
    rows.push_back(cfg_row(REG_ENABLE, 8'd1));
    // pc match wins over the opcode match, then the paused task is held.
    rows.push_back(req_row(REQ_DISPATCH, 7'd3, 32'hFFFF_FFFF, 8'h00));
    rows.push_back(req_row(REQ_DISPATCH, 7'd3, 32'h10, 8'h07));
    // Another task hits an opcode breakpoint and takes over the snapshot.
    rows.push_back(req_row(REQ_DISPATCH, 7'd9, 32'h11, 8'h00));
    rows.push_back(req_row(REQ_STEP, 7'd0, 32'h0, 8'h00));
    rows.push_back(req_row(REQ_DISPATCH, 7'd9, 32'h12, 8'h09));
    rows.push_back(cfg_row(REG_STEP_MODE, 8'd1));
    rows.push_back(cfg_row(REG_TASK_SEL, 8'd9));
    rows.push_back(req_row(REQ_DISPATCH, 7'd9, 32'h13, 8'h0A));
    rows.push_back(req_row(REQ_DISPATCH, 7'd4, 32'h14, 8'h00));
    rows.push_back(cfg_row(REG_ENABLE, 8'd0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) begin
      if (rows[k].is_cfg) begin
        wait_until_quiet();
        write_register(rows[k].cfg_reg, rows[k].cfg_val);
      end else begin
        send_request(rows[k].req, rows[k].tsk, rows[k].pc, rows[k].op, rows[k].pinned,
                     rows[k].pin);
      end
    end

    // Random phases, each under its own register setting. Requests lean on
    // small pools of pcs, opcodes and tasks so breakpoints and holds recur.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_until_quiet();
      phase_idx = ph;
      calm = (ph == PHASES - 1);
      if (ph == 5 || ph == 6) phase_sel[ph] = 8'($urandom_range(0, 127));
      write_register(REG_STEP_MODE, {7'b0, phase_step[ph]});
      write_register(REG_TASK_SEL, phase_sel[ph]);
      write_register(REG_ENABLE, {7'b0, phase_on[ph]});
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        req = (pick < 45) ? REQ_DISPATCH :
              (pick < 60) ? REQ_STEP :
              (pick < 69) ? REQ_ADD_PC :
              (pick < 77) ? REQ_REMOVE_PC :
              (pick < 79) ? REQ_CLEAR_PC :
              (pick < 88) ? REQ_ADD_OP :
              (pick < 96) ? REQ_REMOVE_OP : REQ_CLEAR_OP;
        if (!phase_sel[ph][7] && $urandom_range(0, 1) == 1) tsk = phase_sel[ph][6:0];
        else if ($urandom_range(0, 9) < 6) tsk = 7'($urandom_range(0, 3));
        else tsk = 7'($urandom_range(0, 127));
        pc = ($urandom_range(0, 3) == 0) ? $urandom : pc_pool[$urandom_range(0, 9)];
        op = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                         : op_pool[$urandom_range(0, 9)];
        send_request(req, tsk, pc, op, 1'b0, '0);
      end
    end

    wait_until_quiet();
    if (pending_results.size() != 0) begin
      $display("%0t: results never delivered, expected 0 outstanding, got %0d",
               $time, pending_results.size());
      fail_count++;
    end
    $display("Checked %0d results for %0d requests (%0d dispatches): %0d new pauses, %0d holds.",
             results_seen, items_sent, dispatches_sent, pauses_seen, holds_seen);
    $display("Made %0d register writes across step mode, task filters and a long result stall.",
             reg_writes);
    if (fail_count == 0) begin
      $display("vm_breakpoint_step_unit_top verification clean");
    end else begin
      $display("vm_breakpoint_step_unit_top verification failed");
    end
    $finish;
  end

endmodule
